### src/reab_pkg.sv
// Shared constants, codes, types and decode tables of the rotary encoder block.
package reab_pkg;

  // Timing and acceleration constants
  localparam int CHECK_INTERVAL  = 10;
  localparam int DOUBLE_CLICK_MS = 600;
  localparam int HOLD_MS         = 1200;
  localparam int ACCEL_TOP       = 3072;
  localparam int ACCEL_INC       = 25;
  localparam int ACCEL_DEC       = 2;

  localparam int HOLD_LIMIT = HOLD_MS / CHECK_INTERVAL;
  localparam int DC_LIMIT   = DOUBLE_CLICK_MS / CHECK_INTERVAL;
  localparam int DC_LOAD    = (DC_LIMIT > 255) ? 255 : DC_LIMIT;
  localparam int STEP_MAX   = 13;

  localparam int LIMIT_W = 12;
  localparam logic [LIMIT_W-1:0] HOLD_LIMIT_C = LIMIT_W'(HOLD_LIMIT);
  localparam logic [LIMIT_W-1:0] DC_LIMIT_C   = LIMIT_W'(DC_LIMIT);
  localparam logic [7:0]         DC_LOAD_C    = 8'(DC_LOAD);
  localparam logic [3:0]         CHECK_LAST_C = 4'(CHECK_INTERVAL);
  localparam logic [15:0]        ACCEL_DEC_C  = 16'(ACCEL_DEC);
  localparam logic [15:0]        ACCEL_INC_C  = 16'(ACCEL_INC);
  localparam logic [15:0]        ACCEL_LIM_C  = 16'(ACCEL_TOP - ACCEL_INC);

  // Button status codes
  localparam logic [2:0] BTN_OPEN     = 3'd0;
  localparam logic [2:0] BTN_CLICKED  = 3'd1;
  localparam logic [2:0] BTN_DOUBLE   = 3'd2;
  localparam logic [2:0] BTN_HELD     = 3'd3;
  localparam logic [2:0] BTN_RELEASED = 3'd4;

  // Direction codes
  localparam logic [1:0] DIR_NONE = 2'd0;
  localparam logic [1:0] DIR_UP   = 2'd1;
  localparam logic [1:0] DIR_DOWN = 2'd2;

  // Decoder modes
  localparam logic [1:0] DEC_GRAY = 2'd0;
  localparam logic [1:0] DEC_FULL = 2'd1;

  // Operation codes
  localparam logic OP_TICK = 1'b0;
  localparam logic OP_READ = 1'b1;

  // Register indexes
  localparam logic [2:0] REG_ACTIVE_LEVEL   = 3'd0;
  localparam logic [2:0] REG_STEPS_PER_NTCH = 3'd1;
  localparam logic [2:0] REG_DECODER_MODE   = 3'd2;
  localparam logic [2:0] REG_ACCEL_ENABLE   = 3'd3;
  localparam logic [2:0] REG_DBL_CLICK_EN   = 3'd4;
  localparam logic [2:0] REG_BUTTON_PRESENT = 3'd5;

  localparam int APB_ADDR_W = 5;

  typedef struct packed {
    logic       active_level;
    logic [2:0] steps_per_notch;
    logic [1:0] decoder_mode;
    logic       accel_enable;
    logic       double_click_enable;
    logic       button_present;
  } cfg_t;

  typedef struct packed {
    logic op;
    logic pin_a;
    logic pin_b;
    logic pin_button;
  } item_t;

  typedef struct packed {
    logic signed [4:0] step_value;
    logic [1:0]        direction;
    logic [2:0]        button_state;
  } result_t;

  // Table decode: returns {moved, up}; full selects the full table, else half-step.
  function automatic logic [1:0] table_step(input logic full, input logic [3:0] idx);
    logic [1:0] res;
    res = 2'b00;
    if (full) begin
      unique case (idx)
        4'd1, 4'd7, 4'd8, 4'd14:  res = 2'b11;
        4'd2, 4'd4, 4'd11, 4'd13: res = 2'b10;
        default:                  res = 2'b00;
      endcase
    end else begin
      unique case (idx)
        4'd7, 4'd8:  res = 2'b11;
        4'd2, 4'd13: res = 2'b10;
        default:     res = 2'b00;
      endcase
    end
    return res;
  endfunction

endpackage

### src/reab_if.sv
// Valid/ready channel interfaces for input words and result words.
interface reab_in_if;
  logic valid;
  logic ready;
  logic op;
  logic pin_a;
  logic pin_b;
  logic pin_button;

  modport source (output valid, output op, output pin_a, output pin_b,
                  output pin_button, input ready);
  modport sink   (input valid, input op, input pin_a, input pin_b,
                  input pin_button, output ready);
endinterface

interface reab_out_if;
  logic              valid;
  logic              ready;
  logic signed [4:0] step_value;
  logic [1:0]        direction;
  logic [2:0]        button_state;

  modport source (output valid, output step_value, output direction,
                  output button_state, input ready);
  modport sink   (input valid, input step_value, input direction,
                  input button_state, output ready);
endinterface

### src/reab_cfg_regs.sv
// APB configuration registers of the rotary encoder block.
module reab_cfg_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [reab_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready,
  output reab_pkg::cfg_t                 cfg_o
);

  reab_pkg::cfg_t cfg_q, cfg_d;
  logic           wr_en;
  logic [2:0]     reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[4:2];

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (reg_idx)
        reab_pkg::REG_ACTIVE_LEVEL:   cfg_d.active_level        = pwdata[0];
        reab_pkg::REG_STEPS_PER_NTCH: cfg_d.steps_per_notch     = pwdata[2:0];
        reab_pkg::REG_DECODER_MODE:   cfg_d.decoder_mode        = pwdata[1:0];
        reab_pkg::REG_ACCEL_ENABLE:   cfg_d.accel_enable        = pwdata[0];
        reab_pkg::REG_DBL_CLICK_EN:   cfg_d.double_click_enable = pwdata[0];
        reab_pkg::REG_BUTTON_PRESENT: cfg_d.button_present      = pwdata[0];
        default:                      cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{active_level: 1'b0, steps_per_notch: 3'd1, decoder_mode: 2'd0,
                 accel_enable: 1'b1, double_click_enable: 1'b1,
                 button_present: 1'b1};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  always_comb begin
    unique case (reg_idx)
      reab_pkg::REG_ACTIVE_LEVEL:   prdata = {31'd0, cfg_q.active_level};
      reab_pkg::REG_STEPS_PER_NTCH: prdata = {29'd0, cfg_q.steps_per_notch};
      reab_pkg::REG_DECODER_MODE:   prdata = {30'd0, cfg_q.decoder_mode};
      reab_pkg::REG_ACCEL_ENABLE:   prdata = {31'd0, cfg_q.accel_enable};
      reab_pkg::REG_DBL_CLICK_EN:   prdata = {31'd0, cfg_q.double_click_enable};
      reab_pkg::REG_BUTTON_PRESENT: prdata = {31'd0, cfg_q.button_present};
      default:                      prdata = 32'd0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

### src/reab_core.sv
// Input register, encoder state and single-pass tick/read update logic.
module reab_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  reab_pkg::cfg_t    cfg_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  reab_pkg::item_t   in_item_i,
  output logic              res_valid_o,
  input  logic              res_ready_i,
  output reab_pkg::result_t res_o
);

  logic            in_valid_q;
  reab_pkg::item_t in_q;
  logic            advance;

  logic [3:0]  phase_q, phase_d;
  logic [15:0] acc_q, acc_d;
  logic [15:0] lvl_q, lvl_d;
  logic [15:0] pos_q, pos_d;
  logic [15:0] half_q, half_d;
  logic [2:0]  btn_q, btn_d;
  logic [7:0]  press_q, press_d;
  logic [7:0]  win_q, win_d;
  logic [3:0]  div_q, div_d;

  // tick intermediates
  logic        a_on, b_on, moved, pressed;
  logic [1:0]  curr, diff, tstep;
  logic [3:0]  ph_shift;
  logic [15:0] lvl_dec;
  logic [7:0]  press_inc, win_mid;
  logic [3:0]  div_inc;
  // read intermediates
  logic        neg, pos;
  logic [15:0] mag, r16, pn, half_n, r_cl;
  logic [7:0]  accv;
  logic [1:0]  dir;

  assign advance    = in_valid_q && (in_q.op == reab_pkg::OP_TICK || res_ready_i);
  assign in_ready_o = !in_valid_q || advance;
  assign res_valid_o = in_valid_q && (in_q.op == reab_pkg::OP_READ);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_q <= in_item_i;
    end
  end

  always_comb begin
    phase_d = phase_q;
    acc_d   = acc_q;
    lvl_d   = lvl_q;
    pos_d   = pos_q;
    half_d  = half_q;
    btn_d   = btn_q;
    press_d = press_q;
    win_d   = win_q;
    div_d   = div_q;

    a_on     = (in_q.pin_a == cfg_i.active_level);
    b_on     = (in_q.pin_b == cfg_i.active_level);
    pressed  = (in_q.pin_button == cfg_i.active_level);
    moved    = 1'b0;
    curr     = {a_on, a_on ^ b_on};
    diff     = phase_q[1:0] - curr;
    ph_shift = {phase_q[1:0], a_on, b_on};
    tstep    = reab_pkg::table_step(cfg_i.decoder_mode == reab_pkg::DEC_FULL, ph_shift);
    lvl_dec  = lvl_q - reab_pkg::ACCEL_DEC_C;
    press_inc = (press_q != 8'hFF) ? press_q + 8'd1 : press_q;
    div_inc  = div_q + 4'd1;
    win_mid  = win_q;

    accv = cfg_i.accel_enable ? lvl_q[15:8] : 8'd0;
    mag  = {8'd0, accv} + 16'd1;
    neg  = acc_q[15];
    if (cfg_i.steps_per_notch == 3'd2) begin
      pos = !neg && ($signed(acc_q) >= 16'sd2);
    end else if (cfg_i.steps_per_notch == 3'd4) begin
      pos = !neg && ($signed(acc_q) >= 16'sd4);
    end else begin
      pos = !neg && (acc_q != 16'd0);
    end
    r16 = neg ? (16'd0 - mag) : (pos ? mag : 16'd0);
    // truncate toward zero: add one back for a negative odd position
    pn     = pos_q + r16;
    half_n = 16'($signed(pn) >>> 1) + {15'd0, pn[15] & pn[0]};
    dir  = reab_pkg::DIR_NONE;
    if ($signed(r16) > 16'sd13) begin
      r_cl = 16'(reab_pkg::STEP_MAX);
    end else if ($signed(r16) < -16'sd13) begin
      r_cl = 16'd0 - 16'(reab_pkg::STEP_MAX);
    end else begin
      r_cl = r16;
    end

    res_o.step_value   = 5'sd0;
    res_o.direction    = reab_pkg::DIR_NONE;
    res_o.button_state = btn_q;

    if (advance && in_q.op == reab_pkg::OP_TICK) begin
      // acceleration decay, clamp at zero
      if (cfg_i.accel_enable) begin
        lvl_d = lvl_dec[15] ? 16'd0 : lvl_dec;
      end
      if (cfg_i.decoder_mode == reab_pkg::DEC_GRAY) begin
        if (diff[0]) begin
          phase_d = {2'b00, curr};
          acc_d   = diff[1] ? acc_q + 16'd1 : acc_q - 16'd1;
          moved   = 1'b1;
        end
      end else begin
        phase_d = ph_shift;
        if (tstep[1]) begin
          acc_d = tstep[0] ? acc_q + 16'd1 : acc_q - 16'd1;
          moved = 1'b1;
        end
      end
      if (cfg_i.accel_enable && moved && (lvl_d <= reab_pkg::ACCEL_LIM_C)) begin
        lvl_d = lvl_d + reab_pkg::ACCEL_INC_C;
      end

      // button check every CHECK_INTERVAL ticks
      if (div_inc >= reab_pkg::CHECK_LAST_C) begin
        div_d = 4'd0;
        if (cfg_i.button_present) begin
          if (pressed) begin
            press_d = press_inc;
            if (reab_pkg::LIMIT_W'(press_inc) > reab_pkg::HOLD_LIMIT_C) begin
              btn_d = reab_pkg::BTN_HELD;
            end
          end else begin
            if (press_q != 8'd0) begin
              if (btn_q == reab_pkg::BTN_HELD) begin
                btn_d   = reab_pkg::BTN_RELEASED;
                win_mid = 8'd0;
              end else if (win_q > 8'd1) begin
                if (reab_pkg::LIMIT_W'(win_q) < reab_pkg::DC_LIMIT_C) begin
                  btn_d   = reab_pkg::BTN_DOUBLE;
                  win_mid = 8'd0;
                end
              end else begin
                win_mid = cfg_i.double_click_enable ? reab_pkg::DC_LOAD_C : 8'd1;
              end
            end
            press_d = 8'd0;
          end
          // click window countdown
          win_d = win_mid;
          if (win_mid != 8'd0) begin
            if (win_mid <= 8'd2) begin
              win_d = 8'd0;
              btn_d = reab_pkg::BTN_CLICKED;
            end else begin
              win_d = win_mid - 8'd2;
            end
          end
        end
      end else begin
        div_d = div_inc;
      end
    end else if (advance) begin
      if (btn_q != reab_pkg::BTN_HELD) begin
        btn_d = reab_pkg::BTN_OPEN;
      end
      if (btn_q == reab_pkg::BTN_OPEN) begin
        if (cfg_i.steps_per_notch == 3'd2) begin
          acc_d = {15'd0, acc_q[0]};
        end else if (cfg_i.steps_per_notch == 3'd4) begin
          acc_d = {14'd0, acc_q[1:0]};
        end else begin
          acc_d = 16'd0;
        end
        pos_d = pos_q + r16;
        if ($signed(half_n) > $signed(half_q)) begin
          half_d = half_n;
          dir    = reab_pkg::DIR_DOWN;
        end else if ($signed(half_n) < $signed(half_q)) begin
          half_d = half_n;
          dir    = reab_pkg::DIR_UP;
        end
        res_o.step_value = r_cl[4:0];
        res_o.direction  = dir;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= 4'd0;
      acc_q   <= 16'd0;
      lvl_q   <= 16'd0;
      pos_q   <= 16'd0;
      half_q  <= 16'd0;
      btn_q   <= reab_pkg::BTN_OPEN;
      press_q <= 8'd0;
      win_q   <= 8'd0;
      div_q   <= 4'd0;
    end else begin
      phase_q <= phase_d;
      acc_q   <= acc_d;
      lvl_q   <= lvl_d;
      pos_q   <= pos_d;
      half_q  <= half_d;
      btn_q   <= btn_d;
      press_q <= press_d;
      win_q   <= win_d;
      div_q   <= div_d;
    end
  end

endmodule

### src/reab_out_reg.sv
// Result register that holds a finished word until the sink takes it.
module reab_out_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              res_valid_i,
  output logic              res_ready_o,
  input  reab_pkg::result_t res_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output reab_pkg::result_t out_o
);

  logic              valid_q;
  reab_pkg::result_t data_q;

  assign res_ready_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (res_ready_o) begin
      valid_q <= res_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready_o && res_valid_i) begin
      data_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_o       = data_q;

endmodule

### src/rotary_encoder_accel_button.sv
// Top level of the quadrature rotary encoder with acceleration and click button.
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+------------------------------------
//  item_i   | in        | valid/ready        | op, pin_a, pin_b, pin_button
//  result_o | out       | valid/ready        | step_value, direction, button_state
//  apb      | in/out    | psel/penable/pready| paddr, pwdata, prdata
//
//  One word per clock while input ready holds: a word is captured in the input
//  register, then encoder state and result register update in a single pass.
//  A tick word makes no result; a read word makes exactly one result word.
//  A stalled result holds in the result register; input ready drops only when
//  a read sits in the input register and the result register cannot take it.
//  Reset (rst_ni low, asynchronous) clears encoder and valid state, button open.
module rotary_encoder_accel_button (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  reab_in_if.sink                        item_i,
  reab_out_if.source                     result_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [reab_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);

  reab_pkg::cfg_t    cfg;
  reab_pkg::item_t   item;
  reab_pkg::result_t core_res, out_res;
  logic              core_valid, core_ready;

  // Registers: written in the access phase, read back combinationally.
  reab_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Pack the incoming word.
  assign item = '{op: item_i.op, pin_a: item_i.pin_a, pin_b: item_i.pin_b,
                  pin_button: item_i.pin_button};

  // Decode, accelerate, check the button and serve reads.
  reab_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (item_i.valid),
    .in_ready_o  (item_i.ready),
    .in_item_i   (item),
    .res_valid_o (core_valid),
    .res_ready_i (core_ready),
    .res_o       (core_res)
  );

  // Hold the result word until the sink takes it.
  reab_out_reg u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (core_valid),
    .res_ready_o (core_ready),
    .res_i       (core_res),
    .out_valid_o (result_o.valid),
    .out_ready_i (result_o.ready),
    .out_o       (out_res)
  );

  assign result_o.step_value   = out_res.step_value;
  assign result_o.direction    = out_res.direction;
  assign result_o.button_state = out_res.button_state;

endmodule

### src/reab_checker.sv
// Port-level checks of the rotary encoder block and their bind.
module reab_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       item_ready,
  input logic       res_valid,
  input logic       res_ready,
  input logic [4:0] res_step,
  input logic [1:0] res_dir,
  input logic [2:0] res_btn,
  input logic       pready
);

  // A shown result holds until taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && !res_ready |=> res_valid && $stable(res_step) && $stable(res_dir)
      && $stable(res_btn))
    else $error("result word changed while stalled");

  // With no result pending the input side is always open.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !res_valid |-> item_ready)
    else $error("input stalled with empty result register");

  // A busy button blanks step and direction.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && res_btn != 3'd0 |-> res_step == 5'd0 && res_dir == 2'd0)
    else $error("step reported while button busy");

  // Step stays within its saturation range.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> !($signed(res_step) > 5'sd13 || $signed(res_step) < -5'sd13))
    else $error("step out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready low");

endmodule

bind rotary_encoder_accel_button reab_checker u_reab_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .item_ready (item_i.ready),
  .res_valid  (result_o.valid),
  .res_ready  (result_o.ready),
  .res_step   (result_o.step_value),
  .res_dir    (result_o.direction),
  .res_btn    (result_o.button_state),
  .pready     (pready)
);
